### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the CRC engine.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/crcz_pkg.sv
// Package for the zero-init reflected CRC-32 byte engine.
// Holds the beat type, the polynomial and the byte update function; no dependencies.
package crcz_pkg;

   localparam int unsigned CRC_W  = 32;
   localparam int unsigned BYTE_W = 8;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_ZERO = '0;

   // One input beat after the input register
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } beat_type;

   // Reflected CRC update over one byte: eight shift/xor steps
   function automatic logic [CRC_W-1:0] crc_update_byte(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] r;
      logic             low;
      r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         low = r[0];
         r   = r >> 1;
         if (low) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

endpackage

### hw/rtl/crcz_in_reg.sv
// Input register stage of the CRC engine: holds one beat until the core takes it.
// Depends on crcz_pkg.
module crcz_in_reg import crcz_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // last_byte
   output beat_type          beat,
   output logic              beat_valid,
   input  logic              beat_take
);

   logic     valid_ff, valid_in;
   beat_type beat_ff, beat_in;

   // Free when empty or when the held beat leaves this cycle
   assign req_tready = !valid_ff || beat_take;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         beat_in  = '{data_byte: req_tdata, last_byte: req_tlast};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign beat       = beat_ff;
   assign beat_valid = valid_ff;

endmodule

### hw/rtl/crcz_byte_update.sv
// Combinational byte step of the CRC engine.
// Depends on crcz_pkg for the polynomial and the update function.
module crcz_byte_update import crcz_pkg::*; (
   input  logic [CRC_W-1:0]  crc_cur,
   input  logic [BYTE_W-1:0] data_byte,
   output logic [CRC_W-1:0]  crc_next
);

   // eight shift/xor steps, flattened to xor trees by synthesis
   assign crc_next = crc_update_byte(crc_cur, data_byte);

endmodule

### hw/rtl/crc32_zero_init_byte_engine.sv
// Top level of the reflected CRC-32 byte engine, zero init, no final xor.
// Depends on crcz_pkg, crcz_in_reg and crcz_byte_update.
//
//   channel  direction  tdata                 tuser  tlast
//   req      in         [7:0] data_byte       -      last_byte
//   rsp      out        [31:0] crc_value      -      -
//
// One byte per clock sustained unless a last byte waits for the result slot;
// a last byte passes the input register, then the result register, to rsp.
// The loop through the running CRC register and the byte update sets that rate.
// Reset (synchronous, high) clears both stage valids and the running CRC to zero.
// A stalled rsp holds the result; bytes without the last mark keep flowing,
// and a last byte waits in the input register until the result slot is free.
module crc32_zero_init_byte_engine import crcz_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] crc_value
);

   beat_type         beat;
   logic             beat_valid;
   logic             beat_take;
   logic [CRC_W-1:0] crc_next;

   logic [CRC_W-1:0] running_crc_ff, running_crc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0] rsp_crc_ff, rsp_crc_in;

   crcz_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .beat       (beat),
      .beat_valid (beat_valid),
      .beat_take  (beat_take)
   );

   crcz_byte_update u_update (
      .crc_cur   (running_crc_ff),
      .data_byte (beat.data_byte),
      .crc_next  (crc_next)
   );

   // A last beat needs the result slot free or draining
   assign beat_take = beat_valid && !(beat.last_byte && rsp_valid_ff && !rsp_tready);

   // Running CRC: advance per beat, clear after the last one
   always_comb begin
      running_crc_in = running_crc_ff;
      if (beat_take) begin
         running_crc_in = beat.last_byte ? CRC_ZERO : crc_next;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_crc_in   = rsp_crc_ff;
      if (beat_take && beat.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = crc_next;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= CRC_ZERO;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_crc_ff;

endmodule

### hw/rtl/crcz_checker.sv
// Port-level checker for the CRC engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module crcz_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata
);

   // last bytes taken whose CRC has not left yet (at most two in flight)
   logic [1:0] owed_ff, owed_in;
   logic       last_acc;
   logic       rsp_acc;

   assign last_acc = req_tvalid && req_tready && req_tlast;
   assign rsp_acc  = rsp_tvalid && rsp_tready;

   always_comb begin
      owed_in = owed_ff + {1'b0, last_acc} - {1'b0, rsp_acc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= 2'd0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   // a stalled result beat stays up
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped")

   // a stalled result beat keeps its CRC
   `CHK_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp moved")

   // input back-pressure only comes from a blocked result
   `CHK_IMPLY(a_req_stall_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "req stall")

   // no result straight out of reset
   `CHK_IMPLY(a_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid, "rsp after reset")

   // a result needs a last byte taken and not yet answered
   `CHK_IMPLY(a_rsp_needs_last, clock, reset, rsp_tvalid, owed_ff != 2'd0, "rsp without last")

endmodule

bind crc32_zero_init_byte_engine crcz_checker u_crcz_checker (.*);

### tb/tb_crc32_zero_init_byte_engine.sv
`timescale 1ns / 1ps
// Self-checking bench for crc32_zero_init_byte_engine: byte buffers in, one CRC per buffer out.
// Depends on crcz_pkg and the engine RTL; holds its own CRC predictor and result scoreboard.

// Tracks the running CRC of the open buffer and the CRCs still owed by the engine
class crc_scoreboard;
   localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;

   logic [31:0] running_crc = '0;
   logic [31:0] owed_crc[$];
   int unsigned failures = 0;

   // Bit-serial reflected update, data taken LSB first
   static function logic [31:0] fold_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] acc;
      logic        fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ b[i];
         acc = acc >> 1;
         if (fb) begin
            acc = acc ^ REFLECTED_POLY;
         end
      end
      return acc;
   endfunction

   // Accepted input beat
   function void note_byte(logic [7:0] b, logic last);
      running_crc = fold_byte(running_crc, b);
      if (last) begin
         owed_crc.push_back(running_crc);
         running_crc = '0;
      end
   endfunction

   // Accepted result beat
   function void check_crc(logic [31:0] got);
      logic [31:0] want;
      if (owed_crc.size() == 0) begin
         $error("crc_value: unexpected result, expected none, got %08h", got);
         failures++;
      end else begin
         want = owed_crc.pop_front();
         if (got !== want) begin
            $error("crc_value mismatch: expected %08h, got %08h", want, got);
            failures++;
         end
      end
   endfunction

   function int unsigned outstanding();
      return owed_crc.size();
   endfunction
endclass

module tb_crc32_zero_init_byte_engine;
   import crcz_pkg::*;

   localparam int unsigned TOTAL_BYTES = 1200;
   localparam int unsigned TAIL_BYTES  = 200;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned DRAIN_WAIT  = 8;

   // buffer fill kinds
   localparam int unsigned FILL_RANDOM = 0;
   localparam int unsigned FILL_ZEROS  = 1;
   localparam int unsigned FILL_ONES   = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic        req_tlast = 1'b0;  // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] crc_value

   crc_scoreboard crc_sb = new;

   int unsigned bytes_sent = 0;
   bit          tail_phase = 1'b0;  // no idling on either side
   bit          calm_buffer = 1'b0; // current buffer sent without gaps
   bit          hold_request = 1'b0;

   crc32_zero_init_byte_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Offer one byte and wait for its handshake; maybe idle afterwards
   task automatic send_beat(input logic [7:0] b, input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      crc_sb.note_byte(b, last);
      bytes_sent++;
      if (!tail_phase && !calm_buffer && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Buffer of given length and fill kind
   task automatic send_buffer(input int unsigned len, input int unsigned fill);
      logic [7:0] b;
      for (int unsigned i = 0; i < len; i++) begin
         case (fill)
            FILL_ZEROS: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_beat(b, i == len - 1);
      end
   endtask

   // Sender stops offering until every owed CRC has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (crc_sb.outstanding() != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts, plus one long hold on request
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 8) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         crc_sb.check_crc(rsp_tdata);
      end
   end

   // Watchdog: ends the run when no beat moves for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[crc32_zero_init_byte_engine] ERROR");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      int unsigned len;
      int unsigned pick;
      logic [7:0]  check_str [9];
      check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single-byte buffers at the byte extremes and lone bits
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h01, 1'b1);
      send_beat(8'h80, 1'b1);
      // all ones, then all zeros (stays at zero CRC)
      send_buffer(4, FILL_ONES);
      send_buffer(4, FILL_ZEROS);
      // classic nine-character check string
      foreach (check_str[i]) begin
         send_beat(check_str[i], i == 8);
      end
      drain_results();

      // Long receiver hold while short buffers keep coming back to back
      hold_request = 1'b1;
      calm_buffer = 1'b1;
      repeat (40) send_buffer($urandom_range(1, 2), FILL_RANDOM);
      calm_buffer = 1'b0;

      // Random buffers, mostly short
      while (bytes_sent < TOTAL_BYTES) begin
         if (bytes_sent >= TOTAL_BYTES - TAIL_BYTES) begin
            tail_phase = 1'b1;
         end
         if (!tail_phase && $urandom_range(0, 60) == 0) begin
            drain_results();
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            len = $urandom_range(1, 8);
         end else if (pick < 19) begin
            len = $urandom_range(9, 32);
         end else begin
            len = $urandom_range(33, 128);
         end
         calm_buffer = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         send_buffer(len, (pick == 0) ? FILL_ZEROS : (pick == 1) ? FILL_ONES : FILL_RANDOM);
      end

      // Wind down
      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (crc_sb.failures == 0 && crc_sb.outstanding() == 0) begin
         $display("[crc32_zero_init_byte_engine] OK");
      end else begin
         $display("[crc32_zero_init_byte_engine] ERROR");
      end
      $finish;
   end

endmodule
